// File: hdl/mcbd_pkg.sv
package mcbd_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 4 * CH_W;
    localparam int SUM_W      = CH_W + 1;
    localparam int PAIR_W     = 4 * SUM_W;
    localparam int COORD_W    = 12;
    localparam int LEVEL_W    = 4;
    localparam int CFG_W      = 4;
    localparam int SIZE_RESET = 8;

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_SUM
    } back_state_t;

    typedef struct packed {
        logic pop;
        logic load_out;
        logic hold_we;
        logic mem_we;
        logic mem_re;
        logic sum_step;
    } back_ctrl_t;

endpackage

// File: hdl/mcbd_pix_if.sv
interface mcbd_pix_if;
    import mcbd_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] alpha_in;

    modport source (output valid, blue_in, green_in, red_in, alpha_in, input ready);
    modport sink   (input valid, blue_in, green_in, red_in, alpha_in, output ready);
endinterface

// File: hdl/mcbd_res_if.sv
interface mcbd_res_if;
    import mcbd_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] mip_level;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CH_W-1:0]    blue_out;
    logic [CH_W-1:0]    green_out;
    logic [CH_W-1:0]    red_out;
    logic [CH_W-1:0]    alpha_out;
    logic               run_last;

    modport source (output valid, mip_level, pixel_x, pixel_y, blue_out, green_out,
                    red_out, alpha_out, run_last, input ready);
    modport sink   (input valid, mip_level, pixel_x, pixel_y, blue_out, green_out,
                    red_out, alpha_out, run_last, output ready);
endinterface

// File: hdl/mcbd_front.sv
module mcbd_front #(
    parameter int MAX_LOG2 = 12
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic [mcbd_pkg::CFG_W-1:0]                    cfg_wdata,
    mcbd_pix_if.sink                                      pix,
    input  logic                                          q_ready,
    output logic                                          push,
    output logic [2*MAX_LOG2+mcbd_pkg::PIX_W-1:0]         push_data,
    output logic [$clog2(MAX_LOG2+1)-1:0]                 size_log2
);
    import mcbd_pkg::*;

    localparam int W      = MAX_LOG2;
    localparam int LVL_W  = $clog2(MAX_LOG2 + 1);
    localparam int SIZE_R = (SIZE_RESET > MAX_LOG2) ? MAX_LOG2 : SIZE_RESET;

    logic [LVL_W-1:0] size_reg, size_next;
    logic [W-1:0]     col_reg, col_next;
    logic [W-1:0]     row_reg, row_next;
    logic [W:0]       dim;
    logic [W:0]       col_inc;
    logic [W:0]       row_inc;
    pixel_t           pixel;

    assign dim     = (W+1)'(1) << size_reg;
    assign col_inc = {1'b0, col_reg} + (W+1)'(1);
    assign row_inc = {1'b0, row_reg} + (W+1)'(1);

    assign pix.ready = q_ready;
    assign push      = pix.valid && q_ready;

    assign pixel.blue  = pix.blue_in;
    assign pixel.green = pix.green_in;
    assign pixel.red   = pix.red_in;
    assign pixel.alpha = pix.alpha_in;

    assign push_data = {col_reg, row_reg, pixel};
    assign size_log2 = size_reg;

    always_comb
    begin
        size_next = size_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (cfg_we)
        begin
            // saturate oversized sizes, restart the image
            size_next = (int'(cfg_wdata) > MAX_LOG2) ? LVL_W'(MAX_LOG2) : LVL_W'(cfg_wdata);
            col_next  = '0;
            row_next  = '0;
        end
        else if (push)
        begin
            if (col_inc >= dim)
            begin
                col_next = '0;
                row_next = (row_inc >= dim) ? '0 : row_inc[W-1:0];
            end
            else
            begin
                col_next = col_inc[W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= LVL_W'(SIZE_R);
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            size_reg <= size_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

endmodule

// File: hdl/mcbd_queue.sv
module mcbd_queue #(
    parameter int WIDTH = 56
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             in_ready,
    input  logic             pop,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);
    import mcbd_pkg::*;

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/mcbd_back.sv
module mcbd_back #(
    parameter int MAX_LOG2 = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [$clog2(MAX_LOG2+1)-1:0]         size_log2,
    input  logic                                  q_valid,
    input  logic [2*MAX_LOG2+mcbd_pkg::PIX_W-1:0] q_data,
    output logic                                  pop,
    mcbd_res_if.source                            res
);
    import mcbd_pkg::*;

    localparam int W      = MAX_LOG2;
    localparam int LVL_W  = $clog2(MAX_LOG2 + 1);
    localparam int HOLD_W = (MAX_LOG2 > 1) ? $clog2(MAX_LOG2) : 1;
    localparam int DEPTH  = 1 << MAX_LOG2;

    back_state_t state_reg, state_next;
    back_ctrl_t  ctrl;

    logic [W-1:0]      x_reg, y_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [PIX_W-1:0]  c_reg;
    logic [PAIR_W-1:0] pair_reg;
    logic [PAIR_W-1:0] rd_reg;
    logic [PIX_W-1:0]  hold_reg [MAX_LOG2];
    logic [PAIR_W-1:0] mem [DEPTH];

    logic              out_valid_reg;
    logic [LEVEL_W-1:0] o_level_reg;
    logic [COORD_W-1:0] o_x_reg, o_y_reg;
    logic [PIX_W-1:0]  o_pix_reg;
    logic              o_last_reg;

    logic              out_free;
    logic              at_top;
    logic              last;
    logic [PIX_W-1:0]  held;
    logic [PAIR_W-1:0] pair;
    logic [PIX_W-1:0]  avg;
    logic [W:0]        dim, base;
    logic [W-1:0]      idx;
    logic [W-1:0]      q_x, q_y;
    logic [PIX_W-1:0]  q_pix;

    assign {q_x, q_y, q_pix} = q_data;

    assign out_free = !out_valid_reg || res.ready;
    assign at_top   = (lvl_reg == size_log2);
    assign last     = at_top || !x_reg[0] || !y_reg[0];
    assign held     = hold_reg[lvl_reg[HOLD_W-1:0]];

    assign dim  = (W+1)'(1) << size_log2;
    assign base = dim - (dim >> lvl_reg);
    assign idx  = W'(base + {1'b0, x_reg >> 1});

    always_comb
    begin
        logic [SUM_W:0] s;
        for (int i = 0; i < 4; i++)
        begin
            pair[SUM_W*i +: SUM_W] = {1'b0, held[CH_W*i +: CH_W]} + {1'b0, c_reg[CH_W*i +: CH_W]};
            s = {1'b0, rd_reg[SUM_W*i +: SUM_W]} + {1'b0, pair_reg[SUM_W*i +: SUM_W]};
            avg[CH_W*i +: CH_W] = s[SUM_W:2];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (!last)
                    begin
                        state_next = ST_SUM;
                    end
                    else if (!q_valid)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SUM:
            begin
                state_next = ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.pop = q_valid;
            end
            ST_EMIT:
            begin
                ctrl.load_out = out_free;
                ctrl.pop      = out_free && last && q_valid;
                ctrl.hold_we  = out_free && !at_top && !x_reg[0];
                ctrl.mem_we   = out_free && !at_top && x_reg[0] && !y_reg[0];
                ctrl.mem_re   = out_free && !last;
            end
            ST_SUM:
            begin
                ctrl.sum_step = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign pop = ctrl.pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pop)
        begin
            x_reg   <= q_x;
            y_reg   <= q_y;
            c_reg   <= q_pix;
            lvl_reg <= '0;
        end
        else if (ctrl.sum_step)
        begin
            x_reg   <= x_reg >> 1;
            y_reg   <= y_reg >> 1;
            c_reg   <= avg;
            lvl_reg <= lvl_reg + LVL_W'(1);
        end
        if (ctrl.mem_re)
        begin
            pair_reg <= pair;
        end
        if (ctrl.hold_we)
        begin
            hold_reg[lvl_reg[HOLD_W-1:0]] <= c_reg;
        end
        if (ctrl.load_out)
        begin
            o_level_reg <= LEVEL_W'(lvl_reg);
            o_x_reg     <= COORD_W'(x_reg);
            o_y_reg     <= COORD_W'(y_reg);
            o_pix_reg   <= c_reg;
            o_last_reg  <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mem_we)
        begin
            mem[idx] <= pair;
        end
        if (ctrl.mem_re)
        begin
            rd_reg <= mem[idx];
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.mip_level = o_level_reg;
    assign res.pixel_x   = o_x_reg;
    assign res.pixel_y   = o_y_reg;
    assign res.blue_out  = o_pix_reg[CH_W*0 +: CH_W];
    assign res.green_out = o_pix_reg[CH_W*1 +: CH_W];
    assign res.red_out   = o_pix_reg[CH_W*2 +: CH_W];
    assign res.alpha_out = o_pix_reg[CH_W*3 +: CH_W];
    assign res.run_last  = o_last_reg;

endmodule

// File: hdl/mip_chain_box_downsampler_unit.sv
// Path: an accepted request is written into the queue, popped into the back end's registers and
//   then loaded into the result register. Each result takes an emit step, and each completed
//   2x2 block adds a sum step (row-pair memory read and averaging).
// Reset: asynchronous, active low; clears counters, queue, FSM and result valid, and sets
//   size_log2 to 8. Holding and row-pair stores are not cleared: raster order writes first.
module mip_chain_box_downsampler_unit #(
    parameter int MAX_LOG2 = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [mcbd_pkg::CFG_W-1:0] cfg_wdata,
    mcbd_pix_if.sink                   pix,
    mcbd_res_if.source                 res
);
    import mcbd_pkg::*;

    localparam int LVL_W = $clog2(MAX_LOG2 + 1);
    localparam int ENT_W = 2 * MAX_LOG2 + PIX_W;

    // Front end: take the request, tag it with its level-0 position, advance the raster counters.
    logic             push;
    logic [ENT_W-1:0] push_data;
    logic             q_ready;
    logic [LVL_W-1:0] size_log2;

    // Queue between front and back so either side can stall on its own.
    logic             q_valid;
    logic [ENT_W-1:0] q_data;
    logic             pop;

    mcbd_front #(
        .MAX_LOG2 (MAX_LOG2)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pix       (pix),
        .q_ready   (q_ready),
        .push      (push),
        .push_data (push_data),
        .size_log2 (size_log2)
    );

    mcbd_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .in_ready  (q_ready),
        .pop       (pop),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    // Back end: emit level 0, then walk down the chain one level at a time, holding even
    // columns, storing even-row pair sums and averaging on odd rows.
    mcbd_back #(
        .MAX_LOG2 (MAX_LOG2)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .size_log2 (size_log2),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .res       (res)
    );

endmodule

// File: hdl/mcbd_checker.sv
module mcbd_checker #(
    parameter int MAX_LOG2 = 12
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [mcbd_pkg::LEVEL_W-1:0] mip_level,
    input logic [mcbd_pkg::COORD_W-1:0] pixel_x,
    input logic [mcbd_pkg::COORD_W-1:0] pixel_y,
    input logic [mcbd_pkg::PIX_W-1:0]   pixel,
    input logic                         run_last
);
    import mcbd_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(pixel) && $stable(mip_level)
            && $stable(pixel_x) && $stable(pixel_y) && $stable(run_last))
        else $error("stalled result changed");

    // drop results during reset
    assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // a cascade continues only from an odd column on an odd row
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !run_last |-> pixel_x[0] && pixel_y[0])
        else $error("non-final result at even position");

    // coordinates shrink with level
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (mip_level != '0) |->
            ((int'(pixel_x) >> (MAX_LOG2 - int'(mip_level))) == 0)
            && ((int'(pixel_y) >> (MAX_LOG2 - int'(mip_level))) == 0))
        else $error("coordinate out of range for level");

endmodule

bind mip_chain_box_downsampler_unit mcbd_checker #(
    .MAX_LOG2 (MAX_LOG2)
) u_mcbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .mip_level (res.mip_level),
    .pixel_x   (res.pixel_x),
    .pixel_y   (res.pixel_y),
    .pixel     ({res.alpha_out, res.red_out, res.green_out, res.blue_out}),
    .run_last  (res.run_last)
);

// File: tb/testbench.sv
module testbench;
    import mcbd_pkg::*;

    localparam int MAX_LOG2 = 12;

    // One result beat as seen on the output channel; logic so that X or Z compares unequal.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    alpha;
        logic               last;
    } mip_result_t;

    // Mip chain tracker: mirrors the cascade for every accepted level-0 request and
    // keeps the results it predicts, oldest first.
    class mip_chain_tracker;
        int unsigned size_log2;
        int unsigned col_pos;
        int unsigned row_pos;
        bit [PIX_W-1:0]  even_hold [MAX_LOG2];
        bit [PAIR_W-1:0] pair_sums [1 << MAX_LOG2];
        mip_result_t     expected_px [$];
        int              errors;

        function new();
            size_log2 = SIZE_RESET;
            col_pos   = 0;
            row_pos   = 0;
            errors    = 0;
        endfunction

        // Saturate the size and restart at the top-left pixel of a new image.
        function void set_size(int unsigned value);
            size_log2 = (value > MAX_LOG2) ? MAX_LOG2 : value;
            col_pos   = 0;
            row_pos   = 0;
        endfunction

        function int pending();
            return expected_px.size();
        endfunction

        function void note_pixel(pixel_t p);
            bit [CH_W-1:0]  c [4];
            bit [SUM_W-1:0] pair [4];
            bit [SUM_W:0]   quad;
            bit [PAIR_W-1:0] stored;
            int unsigned dim, lvl, x, y, idx;
            mip_result_t cur;

            dim = 1 << size_log2;
            c[0] = p.blue;
            c[1] = p.green;
            c[2] = p.red;
            c[3] = p.alpha;
            x   = col_pos;
            y   = row_pos;
            lvl = 0;
            cur = '{LEVEL_W'(0), COORD_W'(x), COORD_W'(y), c[0], c[1], c[2], c[3], 1'b0};

            while (lvl < size_log2) begin
                // Even column: park the pixel for its right neighbor.
                if (x % 2 == 0) begin
                    even_hold[lvl] = {c[3], c[2], c[1], c[0]};
                    break;
                end
                for (int i = 0; i < 4; i++)
                    pair[i] = {1'b0, even_hold[lvl][CH_W*i +: CH_W]} + {1'b0, c[i]};
                idx = ((dim - (dim >> lvl)) + (x >> 1)) & ((1 << MAX_LOG2) - 1);
                // Even row: store the pair sum for the row below.
                if (y % 2 == 0) begin
                    pair_sums[idx] = {pair[3], pair[2], pair[1], pair[0]};
                    break;
                end
                stored = pair_sums[idx];
                for (int i = 0; i < 4; i++) begin
                    quad = {1'b0, stored[SUM_W*i +: SUM_W]} + {1'b0, pair[i]};
                    c[i] = quad[SUM_W:2];
                end
                x   = x >> 1;
                y   = y >> 1;
                lvl = lvl + 1;
                expected_px.push_back(cur);
                cur = '{LEVEL_W'(lvl), COORD_W'(x), COORD_W'(y), c[0], c[1], c[2], c[3], 1'b0};
            end
            cur.last = 1'b1;
            expected_px.push_back(cur);

            col_pos++;
            if (col_pos >= dim) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= dim)
                    row_pos = 0;
            end
        endfunction

        function void check_result(mip_result_t got);
            mip_result_t want;

            if (expected_px.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: lvl %0d (%0d,%0d) bgra %h %h %h %h last %b",
                             got.level, got.px, got.py, got.blue, got.green, got.red,
                             got.alpha, got.last);
                return;
            end
            want = expected_px.pop_front();
            if (got.level !== want.level || got.px !== want.px || got.py !== want.py ||
                got.blue !== want.blue || got.green !== want.green ||
                got.red !== want.red || got.alpha !== want.alpha ||
                got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected lvl %0d (%0d,%0d) bgra %h %h %h %h last %b",
                             want.level, want.px, want.py, want.blue, want.green, want.red,
                             want.alpha, want.last);
                    $display("          actual   lvl %0d (%0d,%0d) bgra %h %h %h %h last %b",
                             got.level, got.px, got.py, got.blue, got.green, got.red,
                             got.alpha, got.last);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_wdata;

    mcbd_pix_if pix_ch();
    mcbd_res_if res_ch();

    mip_chain_tracker board = new();

    // Idle odds in percent per cycle, set by the stimulus sequence.
    int src_idle_pct = 33;
    int snk_idle_pct = 80;
    // Long receiver hold-offs asked for by the stimulus, served by the receiver process.
    int stalls_asked = 0;

    mip_chain_box_downsampler_unit #(
        .MAX_LOG2(MAX_LOG2)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .pix      (pix_ch),
        .res      (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up after a generous fixed time; a hung block never drains its results.
    initial
    begin
        #2000000;
        $display("** mip_chain_box_downsampler_unit: FAILED **");
        $finish;
    end

    // Bias channel bytes toward the extremes so that both 0 and 255 show up often.
    function automatic logic [CH_W-1:0] rand_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return CH_W'($urandom_range(255));
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.blue  = rand_byte();
        p.green = rand_byte();
        p.red   = rand_byte();
        p.alpha = rand_byte();
        return p;
    endfunction

    // Offer one level-0 request and hold it until the block takes it. Valid is only
    // dropped when an idle cycle is chosen, so it never toggles within one edge.
    task automatic send_pixel(input pixel_t p);
        if ($urandom_range(99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.blue_in  <= p.blue;
        pix_ch.green_in <= p.green;
        pix_ch.red_in   <= p.red;
        pix_ch.alpha_in <= p.alpha;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        board.note_pixel(p);
    endtask

    task automatic send_bgra(input int b, input int g, input int r, input int a);
        pixel_t p;
        p.blue  = CH_W'(b);
        p.green = CH_W'(g);
        p.red   = CH_W'(r);
        p.alpha = CH_W'(a);
        send_pixel(p);
    endtask

    // Stop offering, wait for every predicted result, then let the pipeline settle.
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the size register while the block is idle.
    task automatic write_size(input int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        board.set_size(value);
        cfg_we    <= 1'b0;
    endtask

    // Receiver: check the beat taken at each edge, then pick ready for the next one.
    initial
    begin
        int hold_left;
        int stalls_served;
        mip_result_t got;

        hold_left     = 0;
        stalls_served = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready) begin
                got.level = res_ch.mip_level;
                got.px    = res_ch.pixel_x;
                got.py    = res_ch.pixel_y;
                got.blue  = res_ch.blue_out;
                got.green = res_ch.green_out;
                got.red   = res_ch.red_out;
                got.alpha = res_ch.alpha_out;
                got.last  = res_ch.run_last;
                board.check_result(got);
            end
            // Start a long hold-off when asked, so the block backs up into its input.
            if (stalls_served < stalls_asked) begin
                stalls_served++;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Stimulus: reset, directed requests, then random images at several sizes.
    initial
    begin
        int sizes  [7];
        int counts [7];
        int rnd_idx;

        sizes  = '{1, 2, 3, 0, 5, 4, 12};
        counts = '{12, 48, 64, 6, 20, 256, 10};

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        pix_ch.valid    <= 1'b0;
        pix_ch.blue_in  <= '0;
        pix_ch.green_in <= '0;
        pix_ch.red_in   <= '0;
        pix_ch.alpha_in <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default size after reset: extremes of every channel.
        send_bgra(0, 0, 0, 0);
        send_bgra(255, 255, 255, 255);
        send_bgra(255, 0, 170, 85);

        // One-pixel image: each request yields only its level-0 result.
        write_size(0);
        send_bgra(255, 255, 255, 255);
        send_bgra(0, 0, 0, 0);

        // 2x2 image: check truncation of the average, then wrap into a second image.
        write_size(1);
        send_bgra(1, 255, 0, 255);
        send_bgra(2, 255, 0, 0);
        send_bgra(3, 255, 0, 255);
        send_bgra(0, 255, 0, 0);
        send_bgra(255, 0, 255, 1);
        send_bgra(255, 0, 254, 1);
        send_bgra(255, 0, 255, 1);
        send_bgra(254, 0, 255, 0);

        // Oversized size saturates to the largest supported image.
        write_size(15);
        send_bgra(128, 127, 1, 254);
        send_bgra(127, 128, 254, 1);

        // Random images; idling shifts from sender-light to receiver-light to none.
        rnd_idx = 0;
        foreach (sizes[p]) begin
            write_size(sizes[p]);
            repeat (counts[p]) begin
                if (rnd_idx < 139) begin
                    src_idle_pct = 33;
                    snk_idle_pct = 80;
                end else if (rnd_idx < 278) begin
                    src_idle_pct = 80;
                    snk_idle_pct = 33;
                end else begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                if (rnd_idx == 200)
                    drain();
                if (rnd_idx == 300)
                    stalls_asked++;
                send_pixel(rand_pixel());
                rnd_idx++;
            end
        end

        pix_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        // Leave room for any stray result after the last expected one.
        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("** mip_chain_box_downsampler_unit: PASSED **");
        else
            $display("** mip_chain_box_downsampler_unit: FAILED **");
        $finish;
    end

endmodule
